>>> rtl/assert_macros.svh
// Assertion macros for the checker file, ndv_checker.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");

`endif

>>> rtl/ndv_pkg.sv
// Types, constants and helper functions of the noise drum voice.
// No dependencies.
package ndv_pkg;

    localparam int TICK_STEP    = 1;
    localparam int SWEEP_PERIOD = 735;
    localparam int CW           = 24;
    localparam int LVL_W        = 5;
    localparam int PROD_W       = LVL_W + CW;
    localparam int DIV_STEPS    = LVL_W;
    localparam int DIV_CNT_W    = $clog2(DIV_STEPS);

    localparam logic [CW-1:0] TICK_INC   = CW'(TICK_STEP);
    localparam logic [CW-1:0] SWEEP_TIME = CW'(SWEEP_PERIOD);
    localparam logic [15:0]   RAND_ADD   = 16'h3711;
    localparam logic [5:0]    LEVEL_TOP  = 6'd16;

    localparam logic [7:0] LEVEL_TABLE [17] = '{
        8'd0, 8'd10, 8'd12, 8'd16, 8'd20, 8'd25, 8'd32, 8'd40, 8'd51,
        8'd64, 8'd80, 8'd101, 8'd128, 8'd161, 8'd203, 8'd255, 8'd255
    };

    typedef enum logic [2:0] {
        PH_LOADED  = 3'b001,
        PH_PLAYING = 3'b010,
        PH_ENDED   = 3'b100
    } phase_t;

    typedef struct packed {
        logic        action;
        logic [23:0] duration;
        logic [23:0] tone_period;
        logic [15:0] tone_sweep;
        logic        tone_enable;
        logic        noise_enable;
        logic [4:0]  level;
        logic [23:0] envelope_length;
        logic [23:0] noise_period;
        logic [23:0] noise_sweep_period;
        logic [15:0] noise_sweep_step;
    } in_item_t;

    typedef struct packed {
        logic [7:0] sample;
        logic       segment_done;
        logic       active;
    } out_item_t;

    typedef struct packed {
        logic                 accept;
        logic                 setup;
        logic                 sweep;
        logic                 gen;
        logic                 nsweep;
        logic                 ngen;
        logic                 level;
        logic                 div_step;
        logic                 scale;
        logic                 push;
        logic [DIV_CNT_W-1:0] div_cnt;
    } cmd_t;

    typedef struct packed {
        logic start;
        logic live;
        logic tone_low;
        logic need_div;
    } status_t;

    function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a,
                                              input logic [CW-1:0] b);
        logic [CW:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        sat_add = sum[CW] ? {CW{1'b1}} : sum[CW-1:0];
    endfunction

    function automatic logic [7:0] level_lookup(input logic [5:0] idx);
        level_lookup = (idx > LEVEL_TOP) ? LEVEL_TABLE[16] : LEVEL_TABLE[idx[4:0]];
    endfunction

endpackage

>>> rtl/ndv_in_if.sv
// Input channel of the noise drum voice: valid, ready and one tick or start item.
// Depends on ndv_pkg.
interface ndv_in_if import ndv_pkg::*; ();
    logic     valid;
    logic     ready;
    in_item_t item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

>>> rtl/ndv_out_if.sv
// Output channel of the noise drum voice: valid, ready and one result item.
// Depends on ndv_pkg.
interface ndv_out_if import ndv_pkg::*; ();
    logic      valid;
    logic      ready;
    out_item_t item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

>>> rtl/ndv_ctrl.sv
// Controller of the noise drum voice: sequences one item through the datapath.
// Depends on ndv_pkg.
module ndv_ctrl import ndv_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    input  status_t status,
    output cmd_t    cmd
);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_SETUP  = 10'b00_0000_0010,
        S_SWEEP  = 10'b00_0000_0100,
        S_GEN    = 10'b00_0000_1000,
        S_LEVEL  = 10'b00_0001_0000,
        S_DIV    = 10'b00_0010_0000,
        S_SCALE  = 10'b00_0100_0000,
        S_PUSH   = 10'b00_1000_0000,
        S_NSWEEP = 10'b01_0000_0000,
        S_NGEN   = 10'b10_0000_0000
    } state_t;

    state_t               state_reg, state_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 valid_reg, valid_next;
    logic                 push_ok;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = valid_reg;
    assign push_ok   = !valid_reg || out_ready;

    always_comb
    begin
        cmd          = '0;
        cmd.div_cnt  = cnt_reg;
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        valid_next   = valid_reg && !out_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = (status.start || !status.live) ? S_PUSH : S_SETUP;
                end
            end
            S_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = S_SWEEP;
            end
            S_SWEEP:
            begin
                cmd.sweep  = 1'b1;
                state_next = S_GEN;
            end
            S_GEN:
            begin
                cmd.gen    = 1'b1;
                state_next = status.tone_low ? S_PUSH : S_NSWEEP;
            end
            S_NSWEEP:
            begin
                cmd.nsweep = 1'b1;
                state_next = S_NGEN;
            end
            S_NGEN:
            begin
                cmd.ngen   = 1'b1;
                state_next = S_LEVEL;
            end
            S_LEVEL:
            begin
                cmd.level  = 1'b1;
                cnt_next   = '0;
                state_next = status.need_div ? S_DIV : S_PUSH;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                    state_next = S_SCALE;
            end
            S_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = S_PUSH;
            end
            S_PUSH:
            begin
                if (push_ok)
                begin
                    cmd.push   = 1'b1;
                    valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

endmodule

>>> rtl/ndv_dp.sv
// Datapath of the noise drum voice: segment store, tone and noise generators,
// envelope divider, level table and result register. Depends on ndv_pkg.
module ndv_dp import ndv_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       vol_we,
    input  logic [4:0] vol_wdata,
    input  in_item_t   in_item,
    input  cmd_t       cmd,
    output status_t    status,
    output out_item_t  out_item
);

    // segment fields
    logic [23:0] dur_reg, tper_reg, env_reg, nper_reg, nsp_reg;
    logic [15:0] tsweep_reg, nstep_reg;
    logic [4:0]  lvl_reg;
    logic        ton_reg, non_reg;

    phase_t         phase_reg;
    logic [4:0]     vol_reg;
    logic [CW-1:0]  tpn_reg, npn_reg, rel_reg, tsc_reg, nsc_reg, tpc_reg, npc_reg;
    logic           last_reg, data_reg;
    logic [15:0]    seed_reg;
    logic [PROD_W-1:0] rem_reg;
    logic [LVL_W-1:0]  q_reg;
    logic [7:0]     samp_reg;
    logic           done_reg;
    out_item_t      out_reg;

    logic [CW-1:0]  env_w, dur_w, nsp_w, half_w;
    logic           tone_hi, tone_wrap, tone_low, n_fire, gate, ndata;
    logic [15:0]    seed_next;
    logic [DIV_CNT_W-1:0] shift;
    logic [PROD_W-1:0]    trial;
    logic [LVL_W-1:0]     v;
    logic [2*LVL_W-1:0]   scaled;

    assign env_w  = CW'(env_reg);
    assign dur_w  = CW'(dur_reg);
    assign nsp_w  = CW'(nsp_reg);
    assign half_w = tpn_reg >> 1;

    assign tone_hi   = tpc_reg < half_w;
    assign tone_wrap = tpc_reg > tpn_reg;
    assign tone_low  = ton_reg && !tone_hi && !tone_wrap;
    assign n_fire    = npc_reg >= npn_reg;
    assign gate      = !((env_w != '0) && (rel_reg >= env_w));
    assign seed_next = seed_reg + {seed_reg[13:0], 2'b00} + RAND_ADD;
    assign ndata     = n_fire ? (seed_next[15] && gate) : last_reg;

    assign shift  = DIV_CNT_W'(DIV_STEPS - 1) - cmd.div_cnt;
    assign trial  = PROD_W'(env_w) << shift;
    assign v      = lvl_reg - q_reg;
    assign scaled = {{LVL_W{1'b0}}, v} * {{LVL_W{1'b0}}, vol_reg};

    assign status.start    = in_item.action;
    assign status.live     = (phase_reg != PH_ENDED);
    assign status.tone_low = tone_low;
    assign status.need_div = data_reg && (env_w != '0) && !(rel_reg > env_w);
    assign out_item        = out_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.accept && in_item.action)
        begin
            dur_reg    <= in_item.duration;
            tper_reg   <= in_item.tone_period;
            tsweep_reg <= in_item.tone_sweep;
            ton_reg    <= in_item.tone_enable;
            non_reg    <= in_item.noise_enable;
            lvl_reg    <= in_item.level;
            env_reg    <= in_item.envelope_length;
            nper_reg   <= in_item.noise_period;
            nsp_reg    <= in_item.noise_sweep_period;
            nstep_reg  <= in_item.noise_sweep_step;
        end
        if (cmd.level)
        begin
            rem_reg <= PROD_W'(lvl_reg) * PROD_W'(rel_reg);
            q_reg   <= '0;
        end
        if (cmd.div_step && (rem_reg >= trial))
        begin
            rem_reg        <= rem_reg - trial;
            q_reg[shift]   <= 1'b1;
        end
        if (cmd.push)
        begin
            out_reg.sample       <= samp_reg;
            out_reg.segment_done <= done_reg;
            out_reg.active       <= (phase_reg != PH_ENDED);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_ENDED;
            vol_reg   <= '0;
            tpn_reg   <= '0;
            npn_reg   <= '0;
            rel_reg   <= '0;
            tsc_reg   <= '0;
            nsc_reg   <= '0;
            tpc_reg   <= '0;
            npc_reg   <= '0;
            last_reg  <= 1'b0;
            data_reg  <= 1'b0;
            seed_reg  <= '0;
            samp_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            if (vol_we)
                vol_reg <= vol_wdata;

            if (cmd.accept)
            begin
                samp_reg <= '0;
                done_reg <= 1'b0;
                if (in_item.action)
                    phase_reg <= PH_LOADED;
            end

            if (cmd.setup)
            begin
                if (phase_reg == PH_LOADED)
                begin
                    tpn_reg   <= CW'(tper_reg);
                    npn_reg   <= CW'(nper_reg);
                    rel_reg   <= TICK_INC;
                    tsc_reg   <= ton_reg ? TICK_INC : '0;
                    nsc_reg   <= '0;
                    phase_reg <= PH_PLAYING;
                end
                else
                begin
                    rel_reg <= sat_add(rel_reg, TICK_INC);
                    if (ton_reg)
                        tsc_reg <= sat_add(tsc_reg, TICK_INC);
                end
                if (ton_reg)
                    tpc_reg <= sat_add(tpc_reg, TICK_INC);
            end

            if (cmd.sweep)
            begin
                if (ton_reg && (tsweep_reg != '0) && (tsc_reg > SWEEP_TIME))
                begin
                    tpn_reg <= sat_add(tpn_reg, CW'(tsweep_reg));
                    tsc_reg <= tsc_reg - SWEEP_TIME;
                end
            end

            if (cmd.gen)
            begin
                if (ton_reg && !tone_hi && tone_wrap)
                    tpc_reg <= tpc_reg - tpn_reg;
                if (!tone_low && non_reg)
                begin
                    nsc_reg <= sat_add(nsc_reg, TICK_INC);
                    npc_reg <= sat_add(npc_reg, TICK_INC);
                end
                data_reg <= ton_reg;
            end

            if (cmd.nsweep)
            begin
                if (non_reg && (nsp_w != '0) && (nsc_reg > nsp_w))
                begin
                    npn_reg <= sat_add(npn_reg, CW'(nstep_reg));
                    nsc_reg <= nsc_reg - nsp_w;
                end
            end

            if (cmd.ngen && non_reg)
            begin
                if (n_fire)
                begin
                    seed_reg <= seed_next;
                    last_reg <= ndata;
                    npc_reg  <= npc_reg - npn_reg;
                end
                data_reg <= ndata;
            end

            if (cmd.level && data_reg)
            begin
                if (env_w == '0)
                begin
                    samp_reg <= level_lookup({1'b0, lvl_reg});
                    if (rel_reg > dur_w)
                    begin
                        done_reg  <= 1'b1;
                        phase_reg <= PH_ENDED;
                    end
                end
                else if (rel_reg > env_w)
                begin
                    done_reg  <= 1'b1;
                    phase_reg <= PH_ENDED;
                end
            end

            if (cmd.scale)
                samp_reg <= level_lookup(scaled[2*LVL_W-1:4]);
        end
    end

endmodule

>>> rtl/noise_drum_voice.sv
// Noise drum voice top level: controller, datapath and channel wiring.
// Depends on ndv_pkg, ndv_in_if, ndv_out_if, ndv_ctrl and ndv_dp.
//
//  channel        | dir | payload
//  ---------------+-----+-----------------------------------------
//  cmd            | in  | action, segment fields (tick or start)
//  res            | out | sample, segment_done, active
//  master_volume  | in  | 5-bit write, no handshake
//
// A start item or a tick of an ended voice goes from transfer straight to push. A
// playing tick passes setup, sweep and generate, then push if the tone is low, else
// noise sweep, noise generate and level, plus 5 restoring envelope divide steps and
// scale when it runs; the next transfer follows the cycle after the result loads.
// A new item is taken while a result still waits in the output register; a result
// stalled downstream holds the next one in its final state.
// Reset clears all control and generator state; there is no clearing pass.
module noise_drum_voice import ndv_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       master_volume_we,
    input  logic [4:0] master_volume_wdata,
    ndv_in_if.sink     cmd,
    ndv_out_if.source  res
);

    cmd_t    ctl_cmd;
    status_t ctl_status;

    ndv_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd.valid),
        .in_ready  (cmd.ready),
        .out_valid (res.valid),
        .out_ready (res.ready),
        .status    (ctl_status),
        .cmd       (ctl_cmd)
    );

    ndv_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .vol_we    (master_volume_we),
        .vol_wdata (master_volume_wdata),
        .in_item   (cmd.item),
        .cmd       (ctl_cmd),
        .status    (ctl_status),
        .out_item  (res.item)
    );

endmodule

>>> rtl/ndv_checker.sv
// Port-level checks of the noise drum voice, bound to the top level.
// Depends on ndv_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ndv_checker import ndv_pkg::*; (
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_item
);

    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    `ASSERT_IMPLIES(a_done_ends, clk, rst_n, out_valid && out_item.segment_done, !out_item.active)
    `ASSERT_IMPLIES(a_idle_silent, clk, rst_n, out_valid && !out_item.active && !out_item.segment_done, out_item.sample == 8'd0)
    `ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_valid && in_ready, !in_ready)

endmodule

bind noise_drum_voice ndv_checker u_ndv_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (cmd.valid),
    .in_ready  (cmd.ready),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .out_item  (res.item)
);
